>>> src/bgc_pkg.sv
// ----------------------------------------------------------------------------
// bgc_pkg
// Shared types, register indexes, event codes and constants for the button
// gesture classifier.
// ----------------------------------------------------------------------------
package bgc_pkg;

    localparam int HOLD_LEVELS = 4;
    localparam int LEVEL_TABLE = 4;
    localparam int HOLD_CNT    = (HOLD_LEVELS < LEVEL_TABLE) ? HOLD_LEVELS : LEVEL_TABLE;

    // event mask bit positions, in emission order
    localparam int EV_DOWN  = 0;
    localparam int EV_HOLD0 = 1;
    localparam int EV_LONG  = EV_HOLD0 + HOLD_CNT;
    localparam int EV_REL   = EV_LONG + 1;
    localparam int EV_SHORT = EV_REL + 1;
    localparam int EV_MULTI = EV_SHORT + 1;
    localparam int EV_NONE  = EV_MULTI + 1;
    localparam int EV_BITS  = EV_NONE + 1;

    // event kinds
    localparam logic [2:0] KIND_NONE     = 3'd0;
    localparam logic [2:0] KIND_DOWN     = 3'd1;
    localparam logic [2:0] KIND_HOLD     = 3'd2;
    localparam logic [2:0] KIND_LONG     = 3'd3;
    localparam logic [2:0] KIND_RELEASED = 3'd4;
    localparam logic [2:0] KIND_SHORT    = 3'd5;
    localparam logic [2:0] KIND_MULTI    = 3'd6;

    // configuration register indexes
    localparam logic [2:0] REG_POLARITY  = 3'd0;
    localparam logic [2:0] REG_DEBOUNCE  = 3'd1;
    localparam logic [2:0] REG_LONG      = 3'd2;
    localparam logic [2:0] REG_WINDOW    = 3'd3;
    localparam logic [2:0] REG_THRESHOLD = 3'd4;
    localparam logic [2:0] REG_POWER     = 3'd5;

    localparam logic [1:0] PM_SCREEN = 2'd1;
    localparam logic [1:0] PM_LOW    = 2'd2;

    localparam logic [15:0] LONG_DEFAULT   = 16'd3000;
    localparam logic [15:0] WINDOW_DEFAULT = 16'd800;
    localparam logic [7:0]  THRESH_DEFAULT = 8'd5;
    localparam logic [31:0] EDGE_BOOST     = 32'd5000;
    localparam logic [6:0]  PERIOD_ACTIVE  = 7'd20;
    localparam logic [6:0]  PERIOD_SCREEN  = 7'd50;
    localparam logic [6:0]  PERIOD_LOW     = 7'd100;

    typedef struct packed {
        logic        polarity_active_low;
        logic [7:0]  debounce_time;
        logic [15:0] long_press_time;
        logic [15:0] tap_window_time;
        logic [7:0]  tap_threshold;
        logic [1:0]  power_mode;
    } cfg_t;

    typedef struct packed {
        logic [EV_BITS-1:0] mask;
        logic [31:0]        held;
        logic [7:0]         taps;
        logic [6:0]         period;
    } evt_t;

    function automatic logic [31:0] level_ms(input int idx);
        logic [31:0] v;
        case (idx)
            0:       v = 32'd1000;
            1:       v = 32'd3000;
            2:       v = 32'd5000;
            3:       v = 32'd10000;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

>>> src/bgc_core.sv
// ----------------------------------------------------------------------------
// bgc_core
// Press tracking state and single-pass event evaluation of one sample.
// ----------------------------------------------------------------------------
module bgc_core (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           adv,
    input  logic           pin_level,
    input  logic [31:0]    time_now,
    input  bgc_pkg::cfg_t  cfg,
    output bgc_pkg::evt_t  evt
);
    import bgc_pkg::*;

    logic                was_pressed_reg, was_pressed_next;
    logic [31:0]         press_start_reg, press_start_next;
    logic                down_sent_reg, down_sent_next;
    logic                long_sent_reg, long_sent_next;
    logic [HOLD_CNT-1:0] hold_sent_reg, hold_sent_next;
    logic [7:0]          tap_count_reg, tap_count_next;
    logic [31:0]         first_tap_reg, first_tap_next;
    logic [31:0]         last_edge_reg, last_edge_next;

    always_comb begin
        logic                pressed;
        logic                press_edge;
        logic [31:0]         start;
        logic [31:0]         held;
        logic                dsent;
        logic                lsent;
        logic [HOLD_CNT-1:0] hsent;
        logic [15:0]         long_t;
        logic [15:0]         window;
        logic [7:0]          thresh;
        logic [7:0]          cnt_inc;
        logic [EV_BITS-1:0]  mask;
        logic                boost;

        pressed    = cfg.polarity_active_low ? !pin_level : pin_level;
        press_edge = pressed && !was_pressed_reg;
        start      = press_edge ? time_now : press_start_reg;
        held       = time_now - start;
        dsent      = press_edge ? 1'b0 : down_sent_reg;
        lsent      = press_edge ? 1'b0 : long_sent_reg;
        hsent      = press_edge ? '0 : hold_sent_reg;
        long_t     = (cfg.long_press_time == '0) ? LONG_DEFAULT : cfg.long_press_time;
        window     = (cfg.tap_window_time == '0) ? WINDOW_DEFAULT : cfg.tap_window_time;
        thresh     = (cfg.tap_threshold == '0) ? THRESH_DEFAULT : cfg.tap_threshold;
        cnt_inc    = (tap_count_reg == 8'hFF) ? tap_count_reg : tap_count_reg + 8'd1;
        mask       = '0;

        was_pressed_next = pressed;
        press_start_next = start;
        down_sent_next   = dsent;
        long_sent_next   = lsent;
        hold_sent_next   = hsent;
        tap_count_next   = tap_count_reg;
        first_tap_next   = first_tap_reg;
        last_edge_next   = press_edge ? time_now : last_edge_reg;

        if (pressed) begin
            if (!dsent && held >= {24'd0, cfg.debounce_time}) begin
                down_sent_next = 1'b1;
                mask[EV_DOWN]  = 1'b1;
            end
            for (int i = 0; i < HOLD_CNT; i++) begin
                if (!hsent[i] && held >= level_ms(i)) begin
                    hold_sent_next[i]  = 1'b1;
                    mask[EV_HOLD0 + i] = 1'b1;
                end
            end
            if (!lsent && held >= {16'd0, long_t}) begin
                long_sent_next = 1'b1;
                mask[EV_LONG]  = 1'b1;
            end
        end else if (was_pressed_reg) begin
            last_edge_next = time_now;
            if (held >= {24'd0, cfg.debounce_time}) begin
                mask[EV_REL] = 1'b1;
                if (!lsent) begin
                    mask[EV_SHORT] = 1'b1;
                    if (tap_count_reg == '0 ||
                        (time_now - first_tap_reg) > {16'd0, window}) begin
                        first_tap_next = time_now;
                        tap_count_next = 8'd1;
                    end else if (cnt_inc >= thresh) begin
                        mask[EV_MULTI] = 1'b1;
                        tap_count_next = '0;
                    end else begin
                        tap_count_next = cnt_inc;
                    end
                end
            end
        end

        if (mask == '0) begin
            mask[EV_NONE] = 1'b1;
        end

        // a release or press this sample puts the edge at now, so only idle
        // samples look at the stored edge time
        boost = pressed || was_pressed_reg || ((time_now - last_edge_reg) < EDGE_BOOST);

        evt.mask = mask;
        evt.held = held;
        evt.taps = cnt_inc;
        if (boost) begin
            evt.period = PERIOD_ACTIVE;
        end else if (cfg.power_mode == PM_SCREEN) begin
            evt.period = PERIOD_SCREEN;
        end else if (cfg.power_mode == PM_LOW) begin
            evt.period = PERIOD_LOW;
        end else begin
            evt.period = PERIOD_ACTIVE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            was_pressed_reg <= 1'b0;
            press_start_reg <= '0;
            down_sent_reg   <= 1'b0;
            long_sent_reg   <= 1'b0;
            hold_sent_reg   <= '0;
            tap_count_reg   <= '0;
            first_tap_reg   <= '0;
            last_edge_reg   <= '0;
        end else if (adv) begin
            was_pressed_reg <= was_pressed_next;
            press_start_reg <= press_start_next;
            down_sent_reg   <= down_sent_next;
            long_sent_reg   <= long_sent_next;
            hold_sent_reg   <= hold_sent_next;
            tap_count_reg   <= tap_count_next;
            first_tap_reg   <= first_tap_next;
            last_edge_reg   <= last_edge_next;
        end
    end

endmodule

>>> src/bgc_emit.sv
// ----------------------------------------------------------------------------
// bgc_emit
// Result register: holds the event set of one sample and sends its events
// one item per cycle while m_ready is high, lowest mask bit first.
// ----------------------------------------------------------------------------
module bgc_emit (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           load_valid,
    output logic           load_ready,
    input  bgc_pkg::evt_t  evt,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [2:0]     m_event_kind,
    output logic [31:0]    m_event_value,
    output logic [6:0]     m_next_poll_period,
    output logic           m_last_of_run
);
    import bgc_pkg::*;

    logic               evt_valid_reg;
    logic [EV_BITS-1:0] mask_reg;
    logic [31:0]        held_reg;
    logic [7:0]         taps_reg;
    logic [6:0]         period_reg;

    logic [EV_BITS-1:0] first_bit;
    logic               last;
    logic               done;

    // isolate lowest set bit
    assign first_bit = mask_reg & (~mask_reg + EV_BITS'(1));
    assign last      = (mask_reg == first_bit);
    assign done      = evt_valid_reg && m_ready && last;
    assign load_ready = !evt_valid_reg || done;

    assign m_valid            = evt_valid_reg;
    assign m_last_of_run      = last;
    assign m_next_poll_period = period_reg;

    always_comb begin
        m_event_kind  = KIND_NONE;
        m_event_value = '0;
        if (first_bit[EV_DOWN]) begin
            m_event_kind = KIND_DOWN;
        end
        for (int i = 0; i < HOLD_CNT; i++) begin
            if (first_bit[EV_HOLD0 + i]) begin
                m_event_kind  = KIND_HOLD;
                m_event_value = level_ms(i);
            end
        end
        if (first_bit[EV_LONG]) begin
            m_event_kind  = KIND_LONG;
            m_event_value = held_reg;
        end
        if (first_bit[EV_REL]) begin
            m_event_kind  = KIND_RELEASED;
            m_event_value = held_reg;
        end
        if (first_bit[EV_SHORT]) begin
            m_event_kind  = KIND_SHORT;
            m_event_value = held_reg;
        end
        if (first_bit[EV_MULTI]) begin
            m_event_kind  = KIND_MULTI;
            m_event_value = {24'd0, taps_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            evt_valid_reg <= 1'b0;
            mask_reg      <= '0;
        end else if (load_valid && load_ready) begin
            evt_valid_reg <= 1'b1;
            mask_reg      <= evt.mask;
        end else if (done) begin
            evt_valid_reg <= 1'b0;
            mask_reg      <= '0;
        end else if (evt_valid_reg && m_ready) begin
            mask_reg <= mask_reg & ~first_bit;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_valid && load_ready) begin
            held_reg   <= evt.held;
            taps_reg   <= evt.taps;
            period_reg <= evt.period;
        end
    end

`ifndef ASSERT_OFF
    a_mask_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        evt_valid_reg |-> (mask_reg != '0))
        else $error("pending event set is empty");

    a_more_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_of_run) |=> m_valid)
        else $error("run ended before its last item");

    a_none_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_event_kind == KIND_NONE) |-> m_last_of_run)
        else $error("quiet item not alone in its run");

    a_load_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (evt_valid_reg && !last) |-> !load_ready)
        else $error("new event set taken mid-run");
`endif

endmodule

>>> src/button_gesture_classifier.sv
// ----------------------------------------------------------------------------
// button_gesture_classifier
// Button debounce, hold level, long press and multi-tap classifier.
// ----------------------------------------------------------------------------
// Each accepted sample (pin level, millisecond timestamp) produces one to six
// result items, one per cycle while m_ready is high; the last carries
// m_last_of_run. A sample is held in the input register, is evaluated in a
// single pass that updates the press state, and its event set moves into the
// result register, which drains one item per cycle while m_ready is high.
// Samples with one result each can stream back to back; a sample with n
// results occupies the result register until all n (six at most) are taken,
// which sets the sustained rate. The first result is presented once the
// sample has moved from the input register into the result register. The
// configuration port is always ready; registers take the low bits of cfg_data.
// ----------------------------------------------------------------------------
module button_gesture_classifier (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_pin_level,
    input  logic [31:0] s_time_now,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_event_kind,
    output logic [31:0] m_event_value,
    output logic [6:0]  m_next_poll_period,
    output logic        m_last_of_run,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import bgc_pkg::*;

    cfg_t        cfg_reg;
    logic        in_valid_reg;
    logic        pin_reg;
    logic [31:0] time_reg;
    logic        emit_ready;
    logic        adv;
    evt_t        evt;

    assign cfg_ready = 1'b1;
    assign adv       = in_valid_reg && emit_ready;
    assign s_ready   = !in_valid_reg || adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.polarity_active_low <= 1'b1;
            cfg_reg.debounce_time       <= 8'd30;
            cfg_reg.long_press_time     <= 16'd3000;
            cfg_reg.tap_window_time     <= 16'd800;
            cfg_reg.tap_threshold       <= 8'd5;
            cfg_reg.power_mode          <= 2'd0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_POLARITY:  cfg_reg.polarity_active_low <= cfg_data[0];
                REG_DEBOUNCE:  cfg_reg.debounce_time       <= cfg_data[7:0];
                REG_LONG:      cfg_reg.long_press_time     <= cfg_data;
                REG_WINDOW:    cfg_reg.tap_window_time     <= cfg_data;
                REG_THRESHOLD: cfg_reg.tap_threshold       <= cfg_data[7:0];
                REG_POWER:     cfg_reg.power_mode          <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            pin_reg  <= s_pin_level;
            time_reg <= s_time_now;
        end
    end

    bgc_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .pin_level (pin_reg),
        .time_now  (time_reg),
        .cfg       (cfg_reg),
        .evt       (evt)
    );

    bgc_emit u_emit (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .load_valid         (in_valid_reg),
        .load_ready         (emit_ready),
        .evt                (evt),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_event_kind       (m_event_kind),
        .m_event_value      (m_event_value),
        .m_next_poll_period (m_next_poll_period),
        .m_last_of_run      (m_last_of_run)
    );

endmodule
